>>> sv/particle_octahedron_expander_macros.svh
// Assertion macros shared by the expander modules.
`ifndef PARTICLE_OCTAHEDRON_EXPANDER_MACROS_SVH
`define PARTICLE_OCTAHEDRON_EXPANDER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define POE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define POE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/poe_pkg.sv
// Shared constants, face table and control types of the octahedron expander.
`timescale 1ns / 1ps
package poe_pkg;

  localparam int MAX_PARTICLES = 4096;
  localparam int LIMIT_RESET   = 4096;
  localparam int CNT_W         = 13;
  localparam int IDX_W         = 15;
  localparam int POS_W         = 32;
  localparam int QUAT_W        = 16;
  localparam int SCL_W         = 24;
  localparam int QPROD_W       = 32;
  localparam int MAT_W         = 34;
  localparam int PROD_W        = SCL_W + 1 + MAT_W;
  localparam int NORM_W        = 16;
  localparam int IN_W          = 232;
  localparam int OUT_W         = 224;

  localparam logic [2:0] LAST_DIR = 3'd5;

  localparam logic [2:0] FACE_TABLE [24] = '{
    3'd0, 3'd2, 3'd4, 3'd2, 3'd1, 3'd4, 3'd1, 3'd3, 3'd4, 3'd3, 3'd0, 3'd4,
    3'd2, 3'd0, 3'd5, 3'd1, 3'd2, 3'd5, 3'd3, 3'd1, 3'd5, 3'd0, 3'd3, 3'd5
  };

  function automatic logic [2:0] face_entry(input logic [4:0] idx);
    return (idx < 5'd24) ? FACE_TABLE[idx] : 3'd0;
  endfunction

  typedef struct packed {
    logic             load;
    logic             qmul;
    logic             mat;
    logic             issue;
    logic [2:0]       k;
    logic [IDX_W-1:0] base;
  } dp_cmd_t;

  typedef struct packed {
    logic adv;
  } dp_sts_t;

endpackage

>>> sv/poe_ctrl.sv
// Sequencer: particle counter, limit register and per-vertex issue control.
`timescale 1ns / 1ps
`include "particle_octahedron_expander_macros.svh"
module poe_ctrl import poe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic             s_axis_tuser,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output dp_cmd_t          cmd,
  input  dp_sts_t          sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_QMUL = 2'd1;
  localparam logic [1:0] ST_MAT  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] counter;
  logic [CNT_W-1:0] limit;
  logic [IDX_W-1:0] base;
  logic [2:0]       k;

  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] lim_eff;
  logic [IDX_W-1:0] base_next;
  logic             run;
  logic             accept;

  assign cnt_eff   = s_axis_tuser ? '0 : counter;
  assign lim_eff   = (limit > CNT_W'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES) : limit;
  assign run       = cnt_eff < lim_eff;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  // effective counter * 6
  assign base_next = IDX_W'({cnt_eff, 2'b00}) + IDX_W'({cnt_eff, 1'b0});
  assign cfg_ready = 1'b1;

  always_comb begin
    cmd.load  = accept && run;
    cmd.qmul  = (state == ST_QMUL);
    cmd.mat   = (state == ST_MAT);
    cmd.issue = (state == ST_EMIT) && sts.adv;
    cmd.k     = k;
    cmd.base  = base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      counter <= '0;
      limit   <= CNT_W'(LIMIT_RESET);
      k       <= '0;
    end else begin
      if (cfg_valid) begin
        limit <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            counter <= run ? cnt_eff + 1'b1 : cnt_eff;
            if (run) begin
              base  <= base_next;
              state <= ST_QMUL;
            end
          end
        end
        ST_QMUL: begin
          state <= ST_MAT;
        end
        ST_MAT: begin
          k     <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (sts.adv) begin
            if (k == LAST_DIR) begin
              state <= ST_IDLE;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `POE_ASSERT_IMP(a_cnt_max, 1'b1, counter <= CNT_W'(MAX_PARTICLES), "counter past maximum")
  `POE_ASSERT_NXT(a_last_idle, cmd.issue && (k == LAST_DIR), state == ST_IDLE, "no return to idle")

endmodule

>>> sv/poe_dp.sv
// Datapath: quaternion products, rotation matrix and the three-stage vertex pipe.
`timescale 1ns / 1ps
`include "particle_octahedron_expander_macros.svh"
module poe_dp import poe_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  dp_cmd_t         cmd,
  output dp_sts_t         sts,
  input  logic [IN_W-1:0] s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic            m_axis_tlast
);

  localparam logic signed [35:0]       MAT_ONE = 36'sd268435456;
  localparam logic signed [PROD_W:0]   OFF_HALF = (PROD_W + 1)'(134217728);
  localparam logic signed [MAT_W:0]    NRM_HALF = (MAT_W + 1)'(8192);
  localparam logic signed [20:0]       NRM_MAX  = 21'sd32767;
  localparam logic signed [20:0]       NRM_MIN  = -21'sd32768;

  // particle registers
  logic signed [POS_W-1:0]   pos [3];
  logic signed [QUAT_W-1:0]  qw, qx, qy, qz;
  logic        [SCL_W-1:0]   scl [3];
  logic signed [QPROD_W-1:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
  logic signed [MAT_W-1:0]   mat [3][3];

  // stage 1: products
  logic                      v1;
  logic signed [PROD_W-1:0]  prod1 [3];
  logic signed [MAT_W-1:0]   col1 [3];
  logic signed [POS_W-1:0]   pos1 [3];
  logic                      neg1, last1;
  logic [IDX_W-1:0]          vnum1;
  logic [IDX_W-1:0]          tidx1 [4];

  // stage 2: rounded offsets and normals
  logic                      v2;
  logic signed [POS_W-1:0]   off2 [3];
  logic signed [NORM_W-1:0]  norm2 [3];
  logic signed [POS_W-1:0]   pos2 [3];
  logic                      last2;
  logic [IDX_W-1:0]          vnum2;
  logic [IDX_W-1:0]          tidx2 [4];

  // output register
  logic                      out_valid;
  logic signed [POS_W-1:0]   out_vert [3];
  logic signed [NORM_W-1:0]  out_norm [3];
  logic [IDX_W-1:0]          out_vnum;
  logic [IDX_W-1:0]          out_tri [4];
  logic                      out_last;

  logic                      adv;
  logic [1:0]                axis;
  logic signed [MAT_W-1:0]   mat_next [3][3];
  logic signed [PROD_W:0]    off_t [3];
  logic signed [MAT_W:0]     nrm_t [3];
  logic signed [20:0]        nrm_q [3];
  logic signed [POS_W:0]     vsum [3];

  function automatic logic signed [MAT_W-1:0] diag_term(
    input logic signed [QPROD_W-1:0] p,
    input logic signed [QPROD_W-1:0] q
  );
    logic signed [35:0] s;
    s = 36'(p) + 36'(q);
    s = MAT_ONE - (s <<< 1);
    return s[MAT_W-1:0];
  endfunction

  function automatic logic signed [MAT_W-1:0] cross_term(
    input logic signed [QPROD_W-1:0] p,
    input logic signed [QPROD_W-1:0] q,
    input logic                      sub
  );
    logic signed [35:0] s;
    s = sub ? (36'(p) - 36'(q)) : (36'(p) + 36'(q));
    s = s <<< 1;
    return s[MAT_W-1:0];
  endfunction

  assign adv     = !out_valid || m_axis_tready;
  assign sts.adv = adv;
  assign axis    = cmd.k[2:1];

  always_comb begin
    mat_next[0][0] = diag_term(pyy, pzz);
    mat_next[0][1] = cross_term(pxy, pwz, 1'b1);
    mat_next[0][2] = cross_term(pxz, pwy, 1'b0);
    mat_next[1][0] = cross_term(pxy, pwz, 1'b0);
    mat_next[1][1] = diag_term(pxx, pzz);
    mat_next[1][2] = cross_term(pyz, pwx, 1'b1);
    mat_next[2][0] = cross_term(pxz, pwy, 1'b1);
    mat_next[2][1] = cross_term(pyz, pwx, 1'b0);
    mat_next[2][2] = diag_term(pxx, pyy);
  end

  // round half up; a minus direction rounds the negated product
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      off_t[c] = neg1 ? (OFF_HALF - (PROD_W + 1)'(prod1[c]))
                      : ((PROD_W + 1)'(prod1[c]) + OFF_HALF);
      nrm_t[c] = neg1 ? (NRM_HALF - (MAT_W + 1)'(col1[c]))
                      : ((MAT_W + 1)'(col1[c]) + NRM_HALF);
      nrm_q[c] = nrm_t[c][MAT_W:14];
      vsum[c]  = (POS_W + 1)'(pos2[c]) + (POS_W + 1)'(off2[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos[0] <= s_axis_tdata[31:0];
      pos[1] <= s_axis_tdata[63:32];
      pos[2] <= s_axis_tdata[95:64];
      qw     <= s_axis_tdata[111:96];
      qx     <= s_axis_tdata[127:112];
      qy     <= s_axis_tdata[143:128];
      qz     <= s_axis_tdata[159:144];
      scl[0] <= s_axis_tdata[183:160];
      scl[1] <= s_axis_tdata[207:184];
      scl[2] <= s_axis_tdata[231:208];
    end
    if (cmd.qmul) begin
      pxx <= qx * qx;
      pyy <= qy * qy;
      pzz <= qz * qz;
      pxy <= qx * qy;
      pxz <= qx * qz;
      pyz <= qy * qz;
      pwx <= qw * qx;
      pwy <= qw * qy;
      pwz <= qw * qz;
    end
    if (cmd.mat) begin
      mat <= mat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= cmd.issue;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cmd.issue) begin
        for (int c = 0; c < 3; c++) begin
          prod1[c] <= $signed({1'b0, scl[axis]}) * mat[c][axis];
          col1[c]  <= mat[c][axis];
          pos1[c]  <= pos[c];
        end
        neg1  <= cmd.k[0];
        last1 <= (cmd.k == LAST_DIR);
        vnum1 <= cmd.base + IDX_W'(cmd.k);
        for (int j = 0; j < 4; j++) begin
          tidx1[j] <= cmd.base + IDX_W'(face_entry({cmd.k, 2'(j)}));
        end
      end
      if (v1) begin
        for (int c = 0; c < 3; c++) begin
          off2[c] <= off_t[c][PROD_W:28];
          pos2[c] <= pos1[c];
          if (nrm_q[c] > NRM_MAX) begin
            norm2[c] <= NRM_MAX[NORM_W-1:0];
          end else if (nrm_q[c] < NRM_MIN) begin
            norm2[c] <= NRM_MIN[NORM_W-1:0];
          end else begin
            norm2[c] <= nrm_q[c][NORM_W-1:0];
          end
        end
        last2 <= last1;
        vnum2 <= vnum1;
        tidx2 <= tidx1;
      end
      if (v2) begin
        for (int c = 0; c < 3; c++) begin
          if (vsum[c][POS_W] != vsum[c][POS_W-1]) begin
            out_vert[c] <= vsum[c][POS_W] ? {1'b1, {(POS_W - 1){1'b0}}}
                                          : {1'b0, {(POS_W - 1){1'b1}}};
          end else begin
            out_vert[c] <= vsum[c][POS_W-1:0];
          end
        end
        out_norm <= norm2;
        out_vnum <= vnum2;
        out_tri  <= tidx2;
        out_last <= last2;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {5'b0, out_tri[3], out_tri[2], out_tri[1], out_tri[0], out_vnum,
                          out_norm[2], out_norm[1], out_norm[0],
                          out_vert[2], out_vert[1], out_vert[0]};

  `POE_ASSERT_IMP(a_issue_adv, cmd.issue, adv, "vertex issued into a stalled pipe")
  `POE_ASSERT_NXT(a_hold_v2, v2 && !adv, v2, "stage two dropped under stall")
  `POE_ASSERT_IMP(a_last_tri, out_valid && out_last, out_tri[3] == out_vnum, "last vertex index mismatch")

endmodule

>>> sv/particle_octahedron_expander.sv
// Top level of the particle octahedron expander: sequencer plus datapath.
//
//  channel  | dir | handshake               | payload
//  s_axis   | in  | s_axis_tvalid/tready    | tdata particle fields, tuser frame_start
//  m_axis   | out | m_axis_tvalid/tready    | tdata vertex fields, tlast last_vertex
//  cfg      | in  | cfg_valid/cfg_ready     | cfg_data particle_limit
//
// A kept particle is handled in order: accept, quaternion products, matrix, then six
// vertex issues, each held back by an output stall; the next accept follows the last
// issue. Each vertex passes the product, rounding and saturation stages. A dropped
// particle is accepted and dropped in the idle state. rst is synchronous; it clears the
// counter and sets the limit to 4096. An output stall freezes the vertex pipe.
`timescale 1ns / 1ps
module particle_octahedron_expander import poe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z
  input  logic [IN_W-1:0]  s_axis_tdata,
  // frame_start
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // vert_x, vert_y, vert_z, norm_x, norm_y, norm_z, vertex_number,
  // tri_index_a, tri_index_b, tri_index_c, tri_index_d, zero pad
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tlast,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  poe_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts)
  );

  poe_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
